@@ hdl/aip_pkg.sv @@
// ----------------------------------------------------------------------------
// aip_pkg
// Shared widths, latencies, reset values, register codes and types of the
// four-point Aitken-Neville interpolator.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int unsigned NUM_POINTS = 4;
  localparam int unsigned MAX_POINTS = 4;
  localparam int unsigned NP         = (NUM_POINTS < 2) ? 2 :
                                       ((NUM_POINTS > MAX_POINTS) ? MAX_POINTS : NUM_POINTS);
  localparam int unsigned NUM_LVL    = NP - 1;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DEN_W      = DATA_W + 1;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned CFG_IDX_W  = $clog2(2 * MAX_POINTS);

  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = DATA_W / DIV_STEPS;
  localparam int unsigned DIV_LAT    = DIV_STAGES + 2;
  localparam int unsigned PRE_LAT    = 4;
  localparam int unsigned COMB_LAT   = PRE_LAT + DIV_LAT;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam data_t NODE_X_RST [MAX_POINTS] = '{
    32'sd65536, 32'sd131072, 32'sd196608, 32'sd262144
  };
  localparam data_t VALUE_Y_RST [MAX_POINTS] = '{
    32'sd65536, 32'sd92680, 32'sd113514, 32'sd131072
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_X0,
    REG_NODE_X1,
    REG_NODE_X2,
    REG_NODE_X3,
    REG_VALUE_Y0,
    REG_VALUE_Y1,
    REG_VALUE_Y2,
    REG_VALUE_Y3
  } cfg_reg_e;

  typedef struct packed {
    logic             neg;
    logic [DEN_W-1:0] mag;
  } den_t;

  typedef struct packed {
    data_t p;
    logic  sat;
  } comb_res_t;

  typedef struct packed {
    logic                     valid;
    logic                     clash;
    logic                     sat;
    logic [NP-1:0][DATA_W-1:0] d;
  } side_t;

  typedef struct packed {
    data_t y;
    logic  clash;
    logic  sat;
  } res_t;

endpackage

@@ hdl/aip_div.sv @@
// ----------------------------------------------------------------------------
// aip_div
// Pipelined truncating divider: unsigned dividend over unsigned divisor,
// several quotient bits per stage, signed result saturated to Q16.16 range.
// ----------------------------------------------------------------------------
module aip_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [aip_pkg::PROD_W-1:0]   dvd_i,
  input  logic                         neg_i,
  input  logic [aip_pkg::DEN_W-1:0]    dsr_i,
  output aip_pkg::comb_res_t           res_o
);
  import aip_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [DATA_W-1:0] quo;
    logic              neg;
    logic              ovf;
  } div_st_t;

  div_st_t   st_d [DIV_STAGES+1];
  div_st_t   st_q [DIV_STAGES+1];
  comb_res_t res_d;
  comb_res_t res_q;
  logic [DATA_W-1:0] quo;

  function automatic div_st_t div_step(div_st_t s, logic [DEN_W-1:0] dsr);
    logic [DEN_W:0] trial;
    div_st_t        r;
    r     = s;
    trial = {s.rem, s.quo[DATA_W-1]} - {1'b0, dsr};
    if (!trial[DEN_W]) begin
      r.rem = trial[DEN_W-1:0];
    end else begin
      r.rem = {s.rem[DEN_W-2:0], s.quo[DATA_W-1]};
    end
    r.quo = {s.quo[DATA_W-2:0], ~trial[DEN_W]};
    return r;
  endfunction

  always_comb begin
    st_d[0].rem = {1'b0, dvd_i[PROD_W-1:DATA_W]};
    st_d[0].quo = dvd_i[DATA_W-1:0];
    st_d[0].neg = neg_i;
    st_d[0].ovf = ({1'b0, dvd_i[PROD_W-1:DATA_W]} >= dsr_i);
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    always_comb begin
      st_d[k] = st_q[k-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        st_d[k] = div_step(st_d[k], dsr_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        st_q[k] <= st_d[k];
      end
      res_q <= res_d;
    end
  end

  assign quo = st_q[DIV_STAGES].quo;

  always_comb begin
    res_d.sat = 1'b0;
    res_d.p   = $signed(quo);
    if (st_q[DIV_STAGES].ovf) begin
      res_d.sat = 1'b1;
      res_d.p   = st_q[DIV_STAGES].neg ? Q_MIN : Q_MAX;
    end else if (st_q[DIV_STAGES].neg) begin
      if (quo[DATA_W-1] && (|quo[DATA_W-2:0])) begin
        res_d.sat = 1'b1;
        res_d.p   = Q_MIN;
      end else begin
        res_d.p   = $signed(~quo + DATA_W'(1));
      end
    end else if (quo[DATA_W-1]) begin
      res_d.sat = 1'b1;
      res_d.p   = Q_MAX;
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/aip_comb.sv @@
// ----------------------------------------------------------------------------
// aip_comb
// One Aitken-Neville combination: two products, difference, magnitude,
// rounding offset, then the pipelined divider.
// ----------------------------------------------------------------------------
module aip_comb (
  input  logic               clk_i,
  input  logic               en_i,
  input  aip_pkg::data_t     pa_i,
  input  aip_pkg::data_t     pb_i,
  input  aip_pkg::data_t     da_i,
  input  aip_pkg::data_t     db_i,
  input  aip_pkg::den_t      den_i,
  output aip_pkg::comb_res_t res_o
);
  import aip_pkg::*;

  logic signed [PROD_W-1:0] prod_a_q;
  logic signed [PROD_W-1:0] prod_b_q;
  logic signed [PROD_W-1:0] num_q;
  logic        [PROD_W-1:0] mag_q;
  logic        [PROD_W-1:0] dvd_q;
  logic                     neg_mag_q;
  logic                     neg_dvd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q  <= pa_i * db_i;
      prod_b_q  <= pb_i * da_i;
      num_q     <= prod_a_q - prod_b_q;
      mag_q     <= num_q[PROD_W-1] ? $unsigned(-num_q) : $unsigned(num_q);
      neg_mag_q <= num_q[PROD_W-1] ^ den_i.neg;
      dvd_q     <= mag_q + PROD_W'(den_i.mag >> 1);
      neg_dvd_q <= neg_mag_q;
    end
  end

  aip_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .dvd_i (dvd_q),
    .neg_i (neg_dvd_q),
    .dsr_i (den_i.mag),
    .res_o (res_o)
  );

endmodule

@@ hdl/aip_obuf.sv @@
// ----------------------------------------------------------------------------
// aip_obuf
// Two-entry output queue: a registered head and a skid entry, so the
// pipeline keeps moving while a result waits to be taken.
// ----------------------------------------------------------------------------
module aip_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  aip_pkg::res_t data_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output aip_pkg::res_t data_o
);
  import aip_pkg::*;

  res_t head_q;
  res_t skid_q;
  logic head_v_q;
  logic skid_v_q;
  logic pop;

  assign pop = head_v_q & ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else if (!push_i) begin
        head_v_q <= 1'b0;
      end
    end else if (push_i) begin
      if (head_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        head_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        head_q <= skid_q;
      end else if (push_i) begin
        head_q <= data_i;
      end
    end else if (push_i) begin
      if (head_v_q) begin
        skid_q <= data_i;
      end else begin
        head_q <= data_i;
      end
    end
  end

  assign space_o = ~skid_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_v_q)
    else $error("push into full output queue");

  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> head_v_q)
    else $error("skid entry valid without head entry");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !pop |=> skid_v_q && $stable(skid_q))
    else $error("waiting transaction dropped from skid entry");
`endif

endmodule

@@ hdl/aitken_interpolation_four_point_core.sv @@
// ----------------------------------------------------------------------------
// aitken_interpolation_four_point_core
// Evaluates the polynomial through four configured Q16.16 nodes at each
// query point with the Aitken-Neville scheme. The block takes one query per
// cycle while in_ready_o is high. An entry register takes the query at
// acceptance, then each of the three levels runs through 14 stages, and an
// output register holds the result. The divider in each level resolves four
// quotient bits per stage over 32 bits. A two-entry output queue decouples
// the sides; in_ready_o drops only while both entries hold results not yet
// taken. Node registers are written through the configuration port only
// while no transaction is in flight; the user must keep to this, the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module aitken_interpolation_four_point_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aip_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [aip_pkg::DATA_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [aip_pkg::DATA_W-1:0]   query_x_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [aip_pkg::DATA_W-1:0]   interp_y_o,
  output logic                                node_clash_o,
  output logic                                saturated_o
);
  import aip_pkg::*;

  data_t            node_x_q  [MAX_POINTS];
  data_t            value_y_q [MAX_POINTS];
  logic             en;
  logic             clash;
  side_t            entry_d;
  side_t            entry_q;
  side_t            side_q    [NUM_LVL][COMB_LAT];
  side_t            side_in   [NUM_LVL];
  side_t            side_bnd  [NUM_LVL];
  data_t            p_in      [NUM_LVL][NP];
  comb_res_t        cres      [NUM_LVL][NP];
  logic [NUM_LVL-1:0] lvl_sat;
  res_t             res_d;
  res_t             res_out;
  logic             push;
  logic             buf_space;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        node_x_q[k]  <= NODE_X_RST[k];
        value_y_q[k] <= VALUE_Y_RST[k];
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_NODE_X0:  node_x_q[0]  <= cfg_data_i;
        REG_NODE_X1:  node_x_q[1]  <= cfg_data_i;
        REG_NODE_X2:  node_x_q[2]  <= cfg_data_i;
        REG_NODE_X3:  node_x_q[3]  <= cfg_data_i;
        REG_VALUE_Y0: value_y_q[0] <= cfg_data_i;
        REG_VALUE_Y1: value_y_q[1] <= cfg_data_i;
        REG_VALUE_Y2: value_y_q[2] <= cfg_data_i;
        REG_VALUE_Y3: value_y_q[3] <= cfg_data_i;
        default:      node_x_q[0]  <= node_x_q[0];
      endcase
    end
  end

  always_comb begin
    clash = 1'b0;
    for (int i = 0; i < NP; i++) begin
      for (int j = 0; j < NP; j++) begin
        if (j > i && node_x_q[i] == node_x_q[j]) begin
          clash = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic signed [DATA_W:0] diff;
    entry_d       = '0;
    entry_d.valid = in_valid_i;
    entry_d.clash = clash;
    for (int k = 0; k < NP; k++) begin
      diff = {query_x_i[DATA_W-1], query_x_i} - {node_x_q[k][DATA_W-1], node_x_q[k]};
      if (diff[DATA_W] != diff[DATA_W-1]) begin
        entry_d.sat  = 1'b1;
        entry_d.d[k] = diff[DATA_W] ? Q_MIN : Q_MAX;
      end else begin
        entry_d.d[k] = diff[DATA_W-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_LVL; k++) begin
      lvl_sat[k] = 1'b0;
      for (int i = 0; i < NP; i++) begin
        lvl_sat[k] = lvl_sat[k] | cres[k][i].sat;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_LVL; k++) begin
      side_bnd[k]     = side_q[k][COMB_LAT-1];
      side_bnd[k].sat = side_q[k][COMB_LAT-1].sat | lvl_sat[k];
    end
    side_in[0] = entry_q;
    for (int k = 1; k < NUM_LVL; k++) begin
      side_in[k] = side_bnd[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      for (int k = 0; k < NUM_LVL; k++) begin
        for (int s = 0; s < COMB_LAT; s++) begin
          side_q[k][s] <= '0;
        end
      end
    end else if (en) begin
      entry_q <= entry_d;
      for (int k = 0; k < NUM_LVL; k++) begin
        side_q[k][0] <= side_in[k];
        for (int s = 1; s < COMB_LAT; s++) begin
          side_q[k][s] <= side_q[k][s-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NUM_LVL; k++) begin : g_lvl
    for (genvar i = 0; i < NP; i++) begin : g_pt
      if (k == 0) begin : g_p_cfg
        assign p_in[k][i] = value_y_q[i];
      end else if (i < NP - k) begin : g_p_prev
        assign p_in[k][i] = cres[k-1][i].p;
      end else begin : g_p_none
        assign p_in[k][i] = '0;
      end

      if (i < NP - 1 - k) begin : g_comb
        den_t                   den_q;
        logic signed [DATA_W:0] den_diff;

        assign den_diff = {node_x_q[i][DATA_W-1], node_x_q[i]}
                        - {node_x_q[i+k+1][DATA_W-1], node_x_q[i+k+1]};

        always_ff @(posedge clk_i) begin
          den_q.neg <= den_diff[DATA_W];
          den_q.mag <= den_diff[DATA_W] ? $unsigned(-den_diff) : $unsigned(den_diff);
        end

        aip_comb u_comb (
          .clk_i (clk_i),
          .en_i  (en),
          .pa_i  (p_in[k][i]),
          .pb_i  (p_in[k][i+1]),
          .da_i  (side_in[k].d[i]),
          .db_i  (side_in[k].d[i+k+1]),
          .den_i (den_q),
          .res_o (cres[k][i])
        );
      end else begin : g_comb_none
        assign cres[k][i] = '0;
      end
    end
  end

  always_comb begin
    res_d.y     = cres[NUM_LVL-1][0].p;
    res_d.clash = 1'b0;
    res_d.sat   = side_bnd[NUM_LVL-1].sat;
    if (side_bnd[NUM_LVL-1].clash) begin
      res_d.y     = '0;
      res_d.clash = 1'b1;
      res_d.sat   = 1'b0;
    end
  end

  assign en         = buf_space;
  assign in_ready_o = en;
  assign push       = en & side_bnd[NUM_LVL-1].valid;

  aip_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_d),
    .space_o (buf_space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_out)
  );

  assign interp_y_o   = res_out.y;
  assign node_clash_o = res_out.clash;
  assign saturated_o  = res_out.sat;

`ifndef SYNTHESIS
  a_clash_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && node_clash_o |-> interp_y_o == '0 && !saturated_o)
    else $error("clash transaction carries nonzero result or saturation");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> entry_q.valid)
    else $error("accepted transaction missing from entry stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_bnd[NUM_LVL-1].valid && !in_ready_o |=> side_bnd[NUM_LVL-1].valid)
    else $error("stalled transaction lost at pipeline end");
`endif

endmodule

@@ bench/aip_result_checker.sv @@
// ----------------------------------------------------------------------------
// aip_result_checker
// Watches the node register writes, the query channel and the result channel
// of the four-point interpolator. It keeps its own copy of the nodes, works
// out the Aitken-Neville value of every accepted query in exact wide integer
// arithmetic, and compares each result transaction field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module aip_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [aip_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [aip_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  aip_pkg::data_t                query_x_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  aip_pkg::data_t                interp_y_i,
  input  logic                          node_clash_i,
  input  logic                          saturated_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            result_count_o,
  output int                            clash_count_o,
  output int                            sat_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import aip_pkg::*;

  typedef logic signed [PROD_W+1:0] wide_t;

  localparam wide_t WIDE_MAX = wide_t'(Q_MAX);
  localparam wide_t WIDE_MIN = wide_t'(Q_MIN);

  data_t node_x  [MAX_POINTS];
  data_t value_y [MAX_POINTS];
  res_t  expected_values [$];

  function automatic wide_t clamp_q(input wide_t v);
    if (v > WIDE_MAX) return WIDE_MAX;
    if (v < WIDE_MIN) return WIDE_MIN;
    return v;
  endfunction

  function automatic res_t interpolate(input data_t x);
    wide_t             p [NP];
    wide_t             xq, da, db, num, den, raw, quo;
    logic [PROD_W+1:0] un, ud, q;
    res_t              r;
    r = '0;
    for (int i = 0; i < NP; i++)
      for (int j = i + 1; j < NP; j++)
        if (node_x[i] == node_x[j]) r.clash = 1'b1;
    if (r.clash) return r;
    xq = x;
    for (int i = 0; i < NP; i++) p[i] = value_y[i];
    for (int lvl = 1; lvl < NP; lvl++) begin
      for (int i = 0; i + lvl < NP; i++) begin
        raw = xq - node_x[i];
        da  = clamp_q(raw);
        if (da != raw) r.sat = 1'b1;
        raw = xq - node_x[i + lvl];
        db  = clamp_q(raw);
        if (db != raw) r.sat = 1'b1;
        num = p[i] * db - p[i + 1] * da;
        den = wide_t'(node_x[i]) - node_x[i + lvl];
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        q   = (un + (ud >> 1)) / ud;
        raw = ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
        quo = clamp_q(raw);
        if (quo != raw) r.sat = 1'b1;
        p[i] = quo;
      end
    end
    r.y = data_t'(p[0]);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        node_x[k]  = NODE_X_RST[k];
        value_y[k] = VALUE_Y_RST[k];
      end
      expected_values.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_NODE_X0:  node_x[0]  = cfg_data_i;
          REG_NODE_X1:  node_x[1]  = cfg_data_i;
          REG_NODE_X2:  node_x[2]  = cfg_data_i;
          REG_NODE_X3:  node_x[3]  = cfg_data_i;
          REG_VALUE_Y0: value_y[0] = cfg_data_i;
          REG_VALUE_Y1: value_y[1] = cfg_data_i;
          REG_VALUE_Y2: value_y[2] = cfg_data_i;
          REG_VALUE_Y3: value_y[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        result_count_o++;
        if (node_clash_i) clash_count_o++;
        if (saturated_i) sat_count_o++;
        if (expected_values.size() == 0) begin
          $error("unexpected result transaction: interp_y %0d", interp_y_i);
          fail_count_o++;
        end else begin
          want = expected_values.pop_front();
          if (interp_y_i !== want.y) begin
            $error("interp_y: expected %0d, actual %0d", want.y, interp_y_i);
            fail_count_o++;
          end
          if (node_clash_i !== want.clash) begin
            $error("node_clash: expected %0b, actual %0b", want.clash, node_clash_i);
            fail_count_o++;
          end
          if (saturated_i !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, saturated_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_values.push_back(interpolate(query_x_i));
    end
    pending_o = expected_values.size();
  end

endmodule

@@ bench/aitken_interpolation_four_point_core_test.sv @@
// ----------------------------------------------------------------------------
// aitken_interpolation_four_point_core_test
// Drives node settings and query points into the interpolator: a directed
// set of extremes, clashing nodes and saturating spans, then random phases
// with fresh nodes and queries aimed near and away from them. Both channels
// idle in random bursts, the result side holds off once to fill the block,
// and a side checker judges every result transaction.
// ----------------------------------------------------------------------------
module aitken_interpolation_four_point_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aip_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 48;
  localparam int HOLD_CYCLES = 150;
  localparam int PIPE_DEPTH  = 2 + COMB_LAT * NUM_LVL;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  data_t                query_x_i   = '0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  data_t                interp_y_o;
  logic                 node_clash_o;
  logic                 saturated_o;

  int    fail_count, pending, result_count, clash_count, sat_count;
  int    query_count   = 0;
  int    setting_count = 0;
  bit    idling        = 1'b1;
  bit    hold_off_req  = 1'b0;
  data_t nx [MAX_POINTS];
  data_t vy [MAX_POINTS];

  aitken_interpolation_four_point_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .query_x_i    (query_x_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .interp_y_o   (interp_y_o),
    .node_clash_o (node_clash_o),
    .saturated_o  (saturated_o)
  );

  aip_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .query_x_i      (query_x_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .interp_y_i     (interp_y_o),
    .node_clash_i   (node_clash_o),
    .saturated_i    (saturated_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .clash_count_o  (clash_count),
    .sat_count_o    (sat_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic write_reg(input cfg_reg_e idx, input data_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_nodes();
    write_reg(REG_NODE_X0, nx[0]);
    write_reg(REG_NODE_X1, nx[1]);
    write_reg(REG_NODE_X2, nx[2]);
    write_reg(REG_NODE_X3, nx[3]);
    write_reg(REG_VALUE_Y0, vy[0]);
    write_reg(REG_VALUE_Y1, vy[1]);
    write_reg(REG_VALUE_Y2, vy[2]);
    write_reg(REG_VALUE_Y3, vy[3]);
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  task automatic send_query(input data_t x);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    query_x_i  <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    query_count++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_style();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 5) return 0;
    if (roll < 18) return 1;
    return 2;
  endfunction

  function automatic data_t pick_value(input int unsigned style);
    case (style)
      0: return data_t'($urandom);
      1: return data_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return data_t'(1);
          default: return data_t'(-1);
        endcase
      end
    endcase
  endfunction

  function automatic data_t pick_query();
    case ($urandom_range(0, 9))
      0, 1, 2: return nx[$urandom_range(0, 3)]
                      + data_t'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      3: return nx[$urandom_range(0, 3)];
      4, 5, 6: return pick_value(1);
      7, 8: return pick_value(0);
      default: return pick_value(2);
    endcase
  endfunction

  task automatic shuffle_nodes();
    for (int k = 0; k < MAX_POINTS; k++) begin
      nx[k] = pick_value(pick_style());
      vy[k] = pick_value(pick_style());
    end
    if ($urandom_range(0, 7) == 0) nx[$urandom_range(1, 3)] = nx[$urandom_range(0, 0)];
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 200_000);
    $display("aitken_interpolation_four_point_core test failed");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < MAX_POINTS; k++) begin
      nx[k] = NODE_X_RST[k];
      vy[k] = VALUE_Y_RST[k];
    end
    send_query('0);
    send_query(32'sd65536);
    send_query(32'sd98304);
    send_query(32'sd163840);
    send_query(32'sd262144);
    send_query(32'sd327680);
    send_query(Q_MAX);
    send_query(Q_MIN);
    send_query(data_t'(-1));

    wait_drained();
    nx = '{Q_MIN, data_t'(-1), data_t'(0), Q_MAX};
    vy = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN};
    load_nodes();
    send_query(Q_MAX);
    send_query(Q_MIN);
    send_query('0);
    send_query(data_t'(1));

    wait_drained();
    nx = '{32'sd65536, 32'sd65536, 32'sd196608, 32'sd262144};
    vy = '{32'sd65536, 32'sd92680, 32'sd113514, 32'sd131072};
    load_nodes();
    send_query(32'sd131072);
    send_query(Q_MIN);

    wait_drained();
    nx = '{32'sd0, 32'sd65536, 32'sd131072, 32'sd131072};
    load_nodes();
    send_query('0);
    send_query(Q_MAX);

    wait_drained();
    nx = '{32'sd0, 32'sd1, 32'sd2, 32'sd3};
    vy = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN};
    load_nodes();
    send_query(Q_MAX);
    send_query(Q_MIN);
    send_query(32'sd100);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      shuffle_nodes();
      load_nodes();
      idling = (ph < NUM_PHASES - 2) && (ph % 3 != 2);
      if (ph == 1) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_query(pick_query());
    end

    wait_drained();
    repeat (2 * PIPE_DEPTH) @(negedge clk_i);
    $display("Sent %0d queries under %0d node settings; %0d results checked.",
             query_count, setting_count, result_count);
    $display("Results with node clash: %0d, with saturation: %0d.", clash_count, sat_count);
    if (fail_count == 0) begin
      $display("aitken_interpolation_four_point_core test passed");
    end else begin
      $display("aitken_interpolation_four_point_core test failed");
    end
    $finish;
  end

endmodule
